// ===== src/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants of the glob wildcard matcher
// symbol codes, default capacity and the structs that run along the cell row
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] SYM_STAR     = 8'd42;  // '*'
  localparam logic [7:0] SYM_QUESTION = 8'd63;  // '?'

  localparam int SYM_W   = 8;
  localparam int TUSER_W = 2;
  localparam int ODATA_W = 8;

  // broadcast control, already qualified by the input transfer
  typedef struct packed {
    logic             rearm;      // pattern item: rebuild start vector
    logic             restart;    // pattern item that opens a new pattern
    logic             load_byte;  // pattern item that carries a byte
    logic             consume;    // subject item that carries a byte
    logic             rewind;     // last subject item: go back to start vector
    logic [SYM_W-1:0] symbol;
  } ctl_t;

  // handed from one cell to the next
  typedef struct packed {
    logic vld;  // position holds a pattern byte (after any restart)
    logic fwd;  // activity entering the next position
  } link_t;

endpackage

// ===== src/gwm_cell.sv =====
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of the matcher
// holds one pattern byte, its fill flag, the live activity bit and the
// activity bit of the freshly armed vector
// ----------------------------------------------------------------------------
module gwm_cell #(
  parameter logic ACT_RST = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gwm_pkg::ctl_t  ctl,
  input  gwm_pkg::link_t link_in,
  output gwm_pkg::link_t link_out,
  output logic           hit,
  output logic           occupied
);
  import gwm_pkg::*;

  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] sym_nxt;
  logic             vld_r, vld_nxt;
  logic             act_r, act_nxt;
  logic             arm_r, arm_nxt;
  logic             vld_eff;
  logic             wr;
  logic             is_star;
  logic             is_quest;
  logic             step;
  logic             keep;
  logic             pos_next;
  logic             act_eff;

  always_comb begin
    vld_eff  = vld_r & ~ctl.restart;
    // first empty slot takes the byte
    wr       = ctl.load_byte & ~vld_eff & link_in.vld;
    vld_nxt  = vld_eff | wr;
    sym_nxt  = wr ? ctl.symbol : sym_r;
    is_star  = (sym_nxt == SYM_STAR);
    is_quest = (sym_nxt == SYM_QUESTION);
    step     = ctl.consume & act_r & vld_r & ~is_star &
               (is_quest | (sym_nxt == ctl.symbol));
    keep     = ctl.consume & act_r & vld_r & is_star;
    pos_next = keep | link_in.fwd;
    // star closure ripples like a carry through runs of stars
    link_out.vld = vld_eff;
    link_out.fwd = step | (pos_next & is_star & vld_nxt);
    act_eff  = ctl.consume ? pos_next : act_r;
    hit      = act_eff & ~vld_r & link_in.vld;
    occupied = vld_r;

    if (ctl.rearm) begin
      act_nxt = pos_next;
    end else if (ctl.rewind) begin
      act_nxt = arm_r;
    end else if (ctl.consume) begin
      act_nxt = pos_next;
    end else begin
      act_nxt = act_r;
    end
    arm_nxt = ctl.rearm ? pos_next : arm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      act_r <= ACT_RST;
      arm_r <= ACT_RST;
    end else begin
      vld_r <= vld_nxt;
      act_r <= act_nxt;
      arm_r <= arm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

endmodule

// ===== src/glob_wildcard_matcher_top.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top: streaming glob matcher
// matches a byte subject against a stored pattern with '*' and '?' wildcards
// ----------------------------------------------------------------------------
// Load a pattern as transfers with tuser mode bit 0, tlast on its final one;
// then stream the subject with mode bit 1, tlast on its final byte. One
// verdict transfer comes out per subject, in the cycle after the subject's last
// transfer. The block takes one transfer per clock, pattern or subject, and
// keeps taking them while a verdict waits, unless the verdict register is
// still full and the sink holds tready low. Each pattern byte lives in one
// cell of a row of MAX_PATTERN cells; the activity vector of all positions is
// updated at once, and the path of that update is the match and star-closure
// ripple through the row (plus an or-reduce for the verdict), which grows
// with MAX_PATTERN. A pattern longer than MAX_PATTERN bytes sets the overflow
// flag and then never matches until a new pattern is loaded. A transfer with
// the no_symbol flag carries no byte and only ends a pattern or subject, so
// empty strings are expressible. Bytes 0, '*' and '?' in the subject are
// literal.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_top #(
  parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gwm_pkg::SYM_W-1:0]   in_tdata,   // [7:0] symbol
  input  logic [gwm_pkg::TUSER_W-1:0] in_tuser,   // [0] mode, [1] no_symbol
  input  logic                        in_tlast,   // last of pattern or subject
  // verdict stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gwm_pkg::ODATA_W-1:0] out_tdata   // [0] matched,
                                                  // [1] pattern_overflow
);
  import gwm_pkg::*;

  ctl_t                 ctl;
  link_t                link [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hit_vec;
  logic [MAX_PATTERN-1:0] occ_vec;

  logic in_fire;
  logic mode;
  logic no_sym;
  logic full;

  // pattern bookkeeping
  logic closed_r, closed_nxt;
  logic ovf_r, ovf_nxt;

  // accept position past the last cell
  logic tail_act_r, tail_act_nxt;
  logic tail_arm_r, tail_arm_nxt;
  logic tail_eff;
  logic hit_any;

  // verdict register
  logic out_valid_r, out_valid_nxt;
  logic matched_r, matched_nxt;
  logic out_ovf_r, out_ovf_nxt;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign mode      = in_tuser[0];
  assign no_sym    = in_tuser[1];

  always_comb begin
    ctl.rearm     = in_fire & ~mode;
    ctl.restart   = in_fire & ~mode & closed_r;
    ctl.load_byte = in_fire & ~mode & ~no_sym;
    ctl.consume   = in_fire & mode & ~no_sym;
    ctl.rewind    = in_fire & mode & in_tlast;
    ctl.symbol    = in_tdata;
  end

  // head of the row: position zero is always seeded on a rearm
  assign link[0].vld = 1'b1;
  assign link[0].fwd = ctl.rearm;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gwm_cell #(
      .ACT_RST ((i == 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .hit      (hit_vec[i]),
      .occupied (occ_vec[i])
    );
  end

  // store already full (after any restart) when a byte arrives
  assign full = link[MAX_PATTERN].vld;

  always_comb begin
    // tail position: active only when the whole full pattern was consumed
    tail_eff = ctl.consume ? link[MAX_PATTERN].fwd : tail_act_r;
    hit_any  = (|hit_vec) | (tail_eff & link[MAX_PATTERN].vld);

    if (ctl.rearm) begin
      tail_act_nxt = link[MAX_PATTERN].fwd;
    end else if (ctl.rewind) begin
      tail_act_nxt = tail_arm_r;
    end else if (ctl.consume) begin
      tail_act_nxt = link[MAX_PATTERN].fwd;
    end else begin
      tail_act_nxt = tail_act_r;
    end
    tail_arm_nxt = ctl.rearm ? link[MAX_PATTERN].fwd : tail_arm_r;

    // pattern open/closed and overflow flag
    closed_nxt = closed_r;
    ovf_nxt    = ovf_r;
    if (in_fire) begin
      if (!mode) begin
        if (closed_r) begin
          ovf_nxt = 1'b0;
        end
        if (ctl.load_byte && full) begin
          ovf_nxt = 1'b1;
        end
        closed_nxt = in_tlast;
      end else begin
        closed_nxt = 1'b1;
      end
    end

    // verdict register
    out_valid_nxt = out_valid_r & ~out_tready;
    matched_nxt   = matched_r;
    out_ovf_nxt   = out_ovf_r;
    if (ctl.rewind) begin
      out_valid_nxt = 1'b1;
      matched_nxt   = hit_any & ~ovf_r;
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r    <= 1'b1;
      ovf_r       <= 1'b0;
      tail_act_r  <= 1'b0;
      tail_arm_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      tail_act_r  <= tail_act_nxt;
      tail_arm_r  <= tail_arm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ODATA_W-2){1'b0}}, out_ovf_r, matched_r};

  // filled cells always form a prefix of the row
  a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec & (occ_vec + 1'b1)) == '0))
    else $error("pattern cells not filled as a prefix");

  // overflow only ever recorded with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> occ_vec[MAX_PATTERN-1])
    else $error("overflow flag without full pattern store");

  // last subject transfer yields a verdict next cycle
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rewind |=> out_valid_r)
    else $error("verdict missing after last subject transfer");

  // a subject transfer always leaves the pattern closed
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode) |=> closed_r)
    else $error("pattern still open after subject transfer");

  // an overflowed pattern never reports a match
  a_no_match_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rewind && ovf_r |=> !matched_r)
    else $error("match reported for overflowed pattern");

endmodule

// ===== tb/sv/glob_wildcard_matcher_top_test.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top_test: self-checking bench for the glob matcher
// streams patterns and subjects with random gaps and sink stalls, tracks the
// pattern store and position activity vector alongside the block, and checks
// every verdict transfer field by field against the predicted one
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gwm_pkg::*;

  localparam int PAT_CAP = MAX_PATTERN_DEF;

  // item kinds carried in tuser bit 0
  localparam bit MODE_PATTERN = 1'b0;
  localparam bit MODE_SUBJECT = 1'b1;

  // plain letters used to build patterns that actually match
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;

  // sink behavior, reselected whenever the 8-bit cycle counter wraps
  localparam logic [1:0] RX_OPEN  = 2'd0;
  localparam logic [1:0] RX_LIGHT = 2'd1;
  localparam logic [1:0] RX_HEAVY = 2'd2;
  localparam logic [1:0] RX_BLOCK = 2'd3;

  // random part of the run; directed tests add roughly 130 more items
  localparam int unsigned RANDOM_ITEMS = 1220;

  typedef logic [7:0] sym_q_t[$];

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SYM_W-1:0]    in_tdata;   // [7:0] symbol
  logic [TUSER_W-1:0]  in_tuser;   // [0] mode, [1] no_symbol
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [ODATA_W-1:0]  out_tdata;  // [0] matched, [1] pattern_overflow

  glob_wildcard_matcher_top #(
    .MAX_PATTERN (PAT_CAP)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous bound, far above the slowest legal run
  initial begin
    #5ms;
    $display("** glob_wildcard_matcher_top: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // glob tracker: pattern bytes, load state and activity of each position
  // --------------------------------------------------------------------------
  logic [7:0]     pat_mem [PAT_CAP];
  int unsigned    pat_len;
  bit             pat_done;
  bit             pat_ovf;
  bit [PAT_CAP:0] live_pos;

  verdict_t pending_verdicts[$];
  int unsigned fault_count;
  int unsigned items_sent;

  // a live star also makes the position right after it live
  function automatic bit [PAT_CAP:0] close_stars(input bit [PAT_CAP:0] v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i] && pat_mem[i] == SYM_STAR) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic bit [PAT_CAP:0] start_vector();
    bit [PAT_CAP:0] v;
    v    = '0;
    v[0] = 1'b1;
    return close_stars(v);
  endfunction

  // advance every live position over one subject byte
  function automatic bit [PAT_CAP:0] advance_over(input logic [7:0] c);
    bit [PAT_CAP:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_mem[i] == SYM_STAR) nxt[i] = 1'b1;
        else if (pat_mem[i] == SYM_QUESTION || pat_mem[i] == c) nxt[i+1] = 1'b1;
      end
    end
    return close_stars(nxt);
  endfunction

  function automatic void glob_track_reset();
    foreach (pat_mem[i]) pat_mem[i] = '0;
    pat_len  = 0;
    pat_done = 1'b1;
    pat_ovf  = 1'b0;
    live_pos = start_vector();
  endfunction

  // fold one accepted input transfer into the tracker, queue any verdict
  function automatic void glob_track_transfer(input bit mode, input logic [7:0] sym,
                                              input bit nosym, input bit last);
    verdict_t v;
    if (mode == MODE_PATTERN) begin
      // first pattern transfer after a closed pattern starts a fresh one
      if (pat_done) begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        pat_done = 1'b0;
      end
      if (!nosym) begin
        if (pat_len < PAT_CAP) begin
          pat_mem[pat_len] = sym;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;  // byte dropped, pattern can no longer match
        end
      end
      if (last) pat_done = 1'b1;
      live_pos = start_vector();
    end else begin
      pat_done = 1'b1;  // a subject closes whatever was loaded so far
      if (!nosym) live_pos = advance_over(sym);
      if (last) begin
        v.matched  = live_pos[pat_len] && !pat_ovf;
        v.overflow = pat_ovf;
        pending_verdicts.push_back(v);
        live_pos = start_vector();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // transfer monitor and verdict checker
  // input side first, so a verdict never races its own expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready === 1'b1)
        glob_track_transfer(in_tuser[0], in_tdata, in_tuser[1], in_tlast);
      if (out_tvalid === 1'b1 && out_tready) begin
        got.matched  = out_tdata[0];
        got.overflow = out_tdata[1];
        if (pending_verdicts.size() == 0) begin
          if (fault_count < 10)
            $display("[%0t] verdict transfer with nothing pending: matched=%b overflow=%b",
                     $realtime, got.matched, got.overflow);
          fault_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            if (fault_count < 10)
              $display("[%0t] verdict mismatch: exp matched=%b ovf=%b got matched=%b ovf=%b",
                       $realtime, want.matched, want.overflow, got.matched, got.overflow);
            fault_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sink: stall style changes whenever the cycle counter wraps, open stretches included
  // --------------------------------------------------------------------------
  logic [7:0]  rx_cycle;
  logic [1:0]  rx_style;
  int unsigned rx_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycle   <= '0;
      rx_style   <= RX_OPEN;
      rx_hold    <= 0;
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 8'd1;
      if (rx_cycle == 8'd0) rx_style <= 2'($urandom_range(0, 3));
      case (rx_style)
        RX_OPEN: begin
          out_tready <= 1'b1;
        end
        RX_LIGHT: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        RX_HEAVY: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          // long stalls of random length
          if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_hold    <= $urandom_range(1, 12);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sender: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_item(input bit mode, input logic [7:0] sym,
                           input bit nosym, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= {nosym, mode};
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
  endtask

  // whole pattern or subject; an empty one, or a split end, closes with a
  // marker transfer that carries no byte
  task automatic send_seq(input bit mode, input sym_q_t q, input bit split_end);
    for (int i = 0; i < q.size(); i++)
      send_item(mode, q[i], 1'b0, (i == q.size() - 1) && !split_end);
    if (q.size() == 0 || split_end)
      send_item(mode, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // random content helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_pattern_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_A;
    if (r < 65) return CH_B;
    if (r < 80) return SYM_STAR;
    if (r < 92) return SYM_QUESTION;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_subject_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_A;
    if (r < 80) return CH_B;
    if (r < 88) return CH_C;
    if (r < 92) return SYM_STAR;
    if (r < 95) return SYM_QUESTION;
    return 8'($urandom_range(0, 255));
  endfunction

  // subject built to fit the pattern, then sometimes damaged
  function automatic sym_q_t subject_for(input sym_q_t p);
    sym_q_t s;
    int unsigned n;
    int unsigned at;
    foreach (p[i]) begin
      if (p[i] == SYM_STAR) begin
        n = $urandom_range(0, 3);
        repeat (n) s.push_back(pick_subject_sym());
      end else if (p[i] == SYM_QUESTION) begin
        s.push_back(pick_subject_sym());
      end else begin
        s.push_back(p[i]);
      end
    end
    if ($urandom_range(0, 9) < 3) begin
      at = (s.size() == 0) ? 0 : $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0: if (s.size() != 0) s[at] = pick_subject_sym();
        1: if (s.size() != 0) s.delete(at);
        default: s.insert(at, pick_subject_sym());
      endcase
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // extremes of the fields, both item kinds and each corner of the protocol
  task automatic test_directed_cases();
    sym_q_t q;
    // empty subject against the empty pattern left by reset
    q.delete();
    send_seq(MODE_SUBJECT, q, 1'b0);
    // lone star matches empty and nonempty subjects
    q = '{SYM_STAR};
    send_seq(MODE_PATTERN, q, 1'b0);
    q.delete();
    send_seq(MODE_SUBJECT, q, 1'b0);
    q = '{CH_A, CH_B};
    send_seq(MODE_SUBJECT, q, 1'b0);
    // byte zero and 0xff as literals; wildcard bytes literal in the subject
    q = '{8'h00, SYM_STAR, SYM_QUESTION, 8'hFF};
    send_seq(MODE_PATTERN, q, 1'b0);
    q = '{8'h00, SYM_QUESTION, SYM_STAR, 8'hFF};
    send_seq(MODE_SUBJECT, q, 1'b0);
    q = '{8'h00, 8'hFF};
    send_seq(MODE_SUBJECT, q, 1'b0);
    q = '{8'hFF};
    send_seq(MODE_SUBJECT, q, 1'b0);
    // marker-only transfer closes a pattern without adding a byte
    send_item(MODE_PATTERN, CH_A, 1'b0, 1'b0);
    send_item(MODE_PATTERN, 8'h5A, 1'b1, 1'b1);
    send_item(MODE_SUBJECT, CH_A, 1'b0, 1'b1);
    // subject arrives while the pattern is still open
    send_item(MODE_PATTERN, CH_B, 1'b0, 1'b0);
    send_item(MODE_SUBJECT, CH_B, 1'b0, 1'b1);
    send_item(MODE_SUBJECT, CH_B, 1'b0, 1'b0);
    send_item(MODE_SUBJECT, CH_C, 1'b1, 1'b1);
    // pattern transfer abandons a subject in progress
    send_item(MODE_SUBJECT, 8'h78, 1'b0, 1'b0);
    send_item(MODE_PATTERN, SYM_QUESTION, 1'b0, 1'b1);
    send_item(MODE_SUBJECT, 8'h7A, 1'b0, 1'b1);
    // empty pattern rejects a star subject and accepts the empty one
    send_item(MODE_PATTERN, SYM_STAR, 1'b1, 1'b1);
    send_item(MODE_SUBJECT, SYM_STAR, 1'b0, 1'b1);
    send_item(MODE_SUBJECT, 8'hA5, 1'b1, 1'b1);
  endtask

  // exactly full store, one byte too many, then recovery on a new pattern
  task automatic test_pattern_overflow();
    sym_q_t q;
    q.delete();
    repeat (PAT_CAP) q.push_back(SYM_QUESTION);
    send_seq(MODE_PATTERN, q, 1'b0);
    q.delete();
    repeat (PAT_CAP) q.push_back(8'($urandom_range(0, 255)));
    send_seq(MODE_SUBJECT, q, 1'b0);
    q.delete();
    repeat (PAT_CAP + 1) q.push_back(SYM_STAR);
    send_seq(MODE_PATTERN, q, 1'b0);
    q.delete();
    send_seq(MODE_SUBJECT, q, 1'b0);
    q = '{CH_A};
    send_seq(MODE_SUBJECT, q, 1'b0);
    q = '{SYM_STAR};
    send_seq(MODE_PATTERN, q, 1'b0);
    q = '{CH_A};
    send_seq(MODE_SUBJECT, q, 1'b0);
  endtask

  // mostly well-formed pattern/subject groups, plus noise and cut-off sequences
  task automatic test_random_sequences();
    int unsigned stop_at;
    int unsigned kind;
    int unsigned plen;
    int unsigned n;
    sym_q_t pat;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n = $urandom_range(0, 99);
        plen = (n < 85) ? $urandom_range(0, 8)
             : (n < 95) ? $urandom_range(9, PAT_CAP)
             : $urandom_range(PAT_CAP + 1, PAT_CAP + 8);
        pat.delete();
        repeat (plen) pat.push_back(pick_pattern_sym());
        send_seq(MODE_PATTERN, pat, $urandom_range(0, 4) == 0);
        n = $urandom_range(1, 4);
        repeat (n) send_seq(MODE_SUBJECT, subject_for(pat), $urandom_range(0, 4) == 0);
      end else if (kind < 90) begin
        // raw transfers with every field random
        n = $urandom_range(1, 8);
        repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
      end else begin
        // sequence cut short; the next group runs into it
        n = $urandom_range(1, 5);
        if ($urandom_range(0, 1) == 0)
          repeat (n) send_item(MODE_PATTERN, pick_pattern_sym(), 1'b0, 1'b0);
        else
          repeat (n) send_item(MODE_SUBJECT, pick_subject_sym(), 1'b0, 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned drain;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tlast  <= 1'b0;
    fault_count = 0;
    items_sent  = 0;
    burst_left  = 0;
    glob_track_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_pattern_overflow();
    test_random_sequences();
    in_tvalid <= 1'b0;

    // let outstanding verdicts drain, then wait for stray transfers
    drain = 0;
    while (pending_verdicts.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);

    if (fault_count == 0 && pending_verdicts.size() == 0) begin
      $display("** glob_wildcard_matcher_top: PASSED **");
    end else begin
      $display("** glob_wildcard_matcher_top: FAILED **");
    end
    $finish;
  end

endmodule
